[hw/rtl/dajc_pkg.sv]
// ----------------------------------------------------------------------------
// Depth auto-range JET colormap package
// Shared types and constants for the colormap controller, datapath and
// register block.
// ----------------------------------------------------------------------------
package dajc_pkg;

    localparam int CFG_W = 16;

    localparam logic REG_FALLBACK = 1'b0;
    localparam logic REG_MIN_SPAN = 1'b1;

    localparam logic [CFG_W-1:0] FALLBACK_RESET = 16'd5000;
    localparam logic [CFG_W-1:0] MIN_SPAN_RESET = 16'd10;

    localparam logic [7:0] CHAN_FULL = 8'd255;

    typedef struct packed {
        logic [CFG_W-1:0] fallback_max_depth;
        logic [CFG_W-1:0] min_span;
    } t_cfg;

    typedef struct packed {
        logic track;
        logic load;
        logic latch;
        logic prep;
        logic div_step;
        logic color;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic need_div;
        logic div_last;
    } t_status;

    typedef enum logic [1:0] {
        SEG_BLUE_CYAN    = 2'd0,
        SEG_CYAN_GREEN   = 2'd1,
        SEG_GREEN_YELLOW = 2'd2,
        SEG_YELLOW_RED   = 2'd3
    } t_seg;

endpackage

[hw/rtl/dajc_regs.sv]
// ----------------------------------------------------------------------------
// Depth auto-range JET colormap configuration registers
// APB-style register block holding the fallback range end and minimum span.
// ----------------------------------------------------------------------------
module dajc_regs
    import dajc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output t_cfg        o_cfg
);

    logic [CFG_W-1:0] r_fallback;
    logic [CFG_W-1:0] r_min_span;
    logic             wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fallback <= FALLBACK_RESET;
            r_min_span <= MIN_SPAN_RESET;
        end else if (wr_en) begin
            unique case (paddr[2])
                REG_FALLBACK: r_fallback <= pwdata[CFG_W-1:0];
                REG_MIN_SPAN: r_min_span <= pwdata[CFG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_FALLBACK: prdata = {{(32-CFG_W){1'b0}}, r_fallback};
            REG_MIN_SPAN: prdata = {{(32-CFG_W){1'b0}}, r_min_span};
            default:      prdata = '0;
        endcase
    end

    assign o_cfg.fallback_max_depth = r_fallback;
    assign o_cfg.min_span           = r_min_span;

endmodule

[hw/rtl/dajc_ctrl.sv]
// ----------------------------------------------------------------------------
// Depth auto-range JET colormap controller
// Runs render requests through range latch, optional division, color, output.
// ----------------------------------------------------------------------------
module dajc_ctrl
    import dajc_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_s_valid,
    input  logic    i_s_command,
    output logic    o_s_ready,
    output logic    o_m_valid,
    input  logic    i_m_ready,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_LATCH = 6'b000010,
        ST_PREP  = 6'b000100,
        ST_DIV   = 6'b001000,
        ST_COLOR = 6'b010000,
        ST_EMIT  = 6'b100000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   out_free;

    assign out_free  = !r_out_valid || i_m_ready;
    assign o_s_ready = (r_state == ST_IDLE);
    assign o_m_valid = r_out_valid;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_s_valid) begin
                    if (i_s_command) begin
                        o_cmd.load = 1'b1;
                        n_state    = ST_LATCH;
                    end else begin
                        o_cmd.track = 1'b1;
                    end
                end
            end
            ST_LATCH: begin
                o_cmd.latch = 1'b1;
                n_state     = ST_PREP;
            end
            ST_PREP: begin
                o_cmd.prep = 1'b1;
                n_state    = i_status.need_div ? ST_DIV : ST_COLOR;
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_status.div_last) begin
                    n_state = ST_COLOR;
                end
            end
            ST_COLOR: begin
                o_cmd.color = 1'b1;
                n_state     = ST_EMIT;
            end
            ST_EMIT: begin
                if (out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        if (o_cmd.emit) begin
            n_out_valid = 1'b1;
        end else if (i_m_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    a_emit_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit |-> (!r_out_valid || i_m_ready))
        else $error("result written over one not yet taken");

    a_emit_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit |=> (r_out_valid && r_state == ST_IDLE))
        else $error("emitted result not presented");

    a_busy_not_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> !(o_cmd.load || o_cmd.track))
        else $error("request taken while busy");

endmodule

[hw/rtl/dajc_datapath.sv]
// ----------------------------------------------------------------------------
// Depth auto-range JET colormap datapath
// Range tracking, range latch, bit-serial normalizing divider and JET mapping.
// ----------------------------------------------------------------------------
module dajc_datapath
    import dajc_pkg::*;
#(
    parameter int DEPTH_BITS         = 16,
    parameter int NORM_FRACTION_BITS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cfg                  i_cfg,
    input  t_cmd                  i_cmd,
    output t_status               o_status,
    input  logic [DEPTH_BITS-1:0] i_depth,
    input  logic                  i_not_finite,
    input  logic                  i_last,
    output logic [7:0]            o_red,
    output logic [7:0]            o_green,
    output logic [7:0]            o_blue,
    output logic                  o_last
);

    localparam int F      = NORM_FRACTION_BITS;
    localparam int SPAN_W = (DEPTH_BITS > CFG_W) ? DEPTH_BITS : CFG_W;
    localparam int CNT_W  = $clog2(F);
    localparam logic [F:0] ONE     = (F+1)'(1) << F;
    localparam logic [F:0] QUARTER = ONE >> 2;

    logic [DEPTH_BITS-1:0] r_lowest, r_highest, r_base;
    logic                  r_any;
    logic [SPAN_W-1:0]     r_span;
    logic [DEPTH_BITS-1:0] r_depth;
    logic                  r_valid, r_last;
    logic [SPAN_W-1:0]     r_rem;
    logic [F:0]            r_n;
    logic [CNT_W-1:0]      r_cnt;
    t_seg                  r_seg;
    logic [F-2:0]          r_u;
    logic [7:0]            r_red, r_green, r_blue;
    logic                  r_out_last;

    logic                  in_valid;
    logic                  use_meas;
    logic [SPAN_W-1:0]     lat_lo, lat_hi, lat_span;
    logic [DEPTH_BITS-1:0] diff;
    logic [SPAN_W-1:0]     diff_ext;
    logic                  below_base, over_span;
    logic [SPAN_W:0]       rem2, rem_sub;
    logic                  rem_ge;
    logic [F:0]            t_val;
    t_seg                  seg;
    logic [F:0]            u_wide;
    logic [F+6:0]          prod;
    logic [7:0]            scaled;
    logic [7:0]            red, green, blue;

    assign in_valid = (i_depth != '0) && !i_not_finite;

    always_comb begin
        use_meas = r_any && (r_lowest < r_highest);
        lat_lo   = use_meas ? SPAN_W'(r_lowest) : '0;
        lat_hi   = use_meas ? SPAN_W'(r_highest) : SPAN_W'(i_cfg.fallback_max_depth);
        lat_span = lat_hi - lat_lo;
        if (lat_span < SPAN_W'(i_cfg.min_span)) begin
            lat_span = SPAN_W'(i_cfg.min_span);
        end
        if (lat_span == '0) begin
            lat_span = SPAN_W'(1);
        end
    end

    assign diff       = r_depth - r_base;
    assign diff_ext   = SPAN_W'(diff);
    assign below_base = !r_valid || (r_depth <= r_base);
    assign over_span  = diff_ext >= r_span;

    assign o_status.need_div = !below_base && !over_span;
    assign o_status.div_last = (r_cnt == CNT_W'(F-1));

    assign rem2    = {r_rem, 1'b0};
    assign rem_ge  = rem2 >= {1'b0, r_span};
    assign rem_sub = rem2 - {1'b0, r_span};

    always_comb begin
        t_val = ONE - r_n;
        priority if (t_val < QUARTER) begin
            seg    = SEG_BLUE_CYAN;
            u_wide = t_val;
        end else if (t_val < (QUARTER << 1)) begin
            seg    = SEG_CYAN_GREEN;
            u_wide = (QUARTER << 1) - t_val;
        end else if (t_val < (QUARTER + (QUARTER << 1))) begin
            seg    = SEG_GREEN_YELLOW;
            u_wide = t_val - (QUARTER << 1);
        end else begin
            seg    = SEG_YELLOW_RED;
            u_wide = ONE - t_val;
        end
    end

    assign prod   = (F+7)'(r_u) * (F+7)'(CHAN_FULL);
    assign scaled = prod[F+5:F-2];

    always_comb begin
        unique case (r_seg)
            SEG_BLUE_CYAN: begin
                red = '0; green = scaled; blue = CHAN_FULL;
            end
            SEG_CYAN_GREEN: begin
                red = '0; green = CHAN_FULL; blue = scaled;
            end
            SEG_GREEN_YELLOW: begin
                red = scaled; green = CHAN_FULL; blue = '0;
            end
            SEG_YELLOW_RED: begin
                red = CHAN_FULL; green = scaled; blue = '0;
            end
            default: begin
                red = '0; green = '0; blue = '0;
            end
        endcase
        if (!r_valid) begin
            red = '0; green = '0; blue = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lowest  <= '1;
            r_highest <= '0;
            r_any     <= 1'b0;
            r_base    <= '0;
            r_span    <= '0;
        end else if (i_cmd.emit && r_last) begin
            r_lowest  <= '1;
            r_highest <= '0;
            r_any     <= 1'b0;
            r_base    <= '0;
            r_span    <= '0;
        end else begin
            if (i_cmd.track && in_valid) begin
                if (i_depth < r_lowest) begin
                    r_lowest <= i_depth;
                end
                if (i_depth > r_highest) begin
                    r_highest <= i_depth;
                end
                r_any <= 1'b1;
            end
            if (i_cmd.latch && (r_span == '0)) begin
                r_base <= DEPTH_BITS'(lat_lo);
                r_span <= lat_span;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_depth <= i_depth;
            r_valid <= in_valid;
            r_last  <= i_last;
        end
        if (i_cmd.prep) begin
            r_rem <= diff_ext;
            r_cnt <= '0;
            r_n   <= (!below_base && over_span) ? ONE : '0;
        end
        if (i_cmd.div_step) begin
            r_rem <= rem_ge ? rem_sub[SPAN_W-1:0] : rem2[SPAN_W-1:0];
            r_n   <= {r_n[F-1:0], rem_ge};
            r_cnt <= r_cnt + CNT_W'(1);
        end
        if (i_cmd.color) begin
            r_seg <= seg;
            r_u   <= u_wide[F-2:0];
        end
        if (i_cmd.emit) begin
            r_red      <= red;
            r_green    <= green;
            r_blue     <= blue;
            r_out_last <= r_last;
        end
    end

    assign o_red   = r_red;
    assign o_green = r_green;
    assign o_blue  = r_blue;
    assign o_last  = r_out_last;

    a_span_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.latch |=> (r_span != '0))
        else $error("divisor is zero after range latch");

    a_rem_below_span: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.div_step |-> (r_rem < r_span))
        else $error("divider remainder out of range");

    a_norm_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.color |-> (r_n <= ONE))
        else $error("normalized depth above one");

    a_clear_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.emit && r_last) |=> (r_span == '0 && !r_any))
        else $error("range state not cleared at end of render pass");

endmodule

[hw/rtl/depth_autorange_jet_colormap_core.sv]
// ----------------------------------------------------------------------------
// Depth auto-range JET colormap core
// Measures the depth range of a frame, then renders it through a JET colormap.
// ----------------------------------------------------------------------------
// A measure request is taken while idle. A render request whose depth falls strictly
// inside the latched range passes through the range latch, preparation, the
// normalizing divider, color and output states; the divider is restoring and
// produces one quotient bit per cycle. Other render requests (invalid pixel, at or below
// the base, or at or above the top) skip the divider. While a result waits in the output
// register the next request is taken. Clearing after the last render pixel is immediate; there is no clearing pass.
module depth_autorange_jet_colormap_core
    import dajc_pkg::*;
#(
    parameter int DEPTH_BITS         = 16,
    parameter int NORM_FRACTION_BITS = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    // depth_mm, zero padded to whole bytes
    input  logic [((DEPTH_BITS+7)/8)*8-1:0]     i_s_axis_tdata,
    // command, not_finite
    input  logic [1:0]                          i_s_axis_tuser,
    input  logic                                i_s_axis_tlast,
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    // red, green, blue
    output logic [23:0]                         o_m_axis_tdata,
    output logic                                o_m_axis_tlast,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [2:0]                          paddr,
    input  logic [31:0]                         pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready
);

    t_cfg       cfg;
    t_cmd       cmd;
    t_status    status;
    logic [7:0] red, green, blue;

    dajc_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    dajc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_valid   (i_s_axis_tvalid),
        .i_s_command (i_s_axis_tuser[0]),
        .o_s_ready   (o_s_axis_tready),
        .o_m_valid   (o_m_axis_tvalid),
        .i_m_ready   (i_m_axis_tready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    dajc_datapath #(
        .DEPTH_BITS         (DEPTH_BITS),
        .NORM_FRACTION_BITS (NORM_FRACTION_BITS)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (cfg),
        .i_cmd        (cmd),
        .o_status     (status),
        .i_depth      (i_s_axis_tdata[DEPTH_BITS-1:0]),
        .i_not_finite (i_s_axis_tuser[1]),
        .i_last       (i_s_axis_tlast),
        .o_red        (red),
        .o_green      (green),
        .o_blue       (blue),
        .o_last       (o_m_axis_tlast)
    );

    assign o_m_axis_tdata = {blue, green, red};

endmodule

[dv/dajc_tb_pkg.sv]
// ----------------------------------------------------------------------------
// Depth colormap verification package
// Pixel command codes shared by the stimulus and the result checker.
// ----------------------------------------------------------------------------
package dajc_tb_pkg;

    typedef enum logic {
        CMD_MEASURE = 1'b0,
        CMD_RENDER  = 1'b1
    } t_pixel_cmd;

endpackage

[dv/jet_pixel_checker.sv]
// ----------------------------------------------------------------------------
// Depth colormap result checker
// Follows register writes and accepted pixel requests, computes the range
// and JET color of every render pixel, and compares each delivered RGB
// result and register read against that prediction.
// ----------------------------------------------------------------------------
module jet_pixel_checker
    import dajc_pkg::*;
    import dajc_tb_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    // depth_mm
    input  logic [15:0] i_s_tdata,
    // command, not_finite
    input  logic [1:0]  i_s_tuser,
    input  logic        i_s_tlast,
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    // red, green, blue
    input  logic [23:0] i_m_tdata,
    input  logic        i_m_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic [31:0] prdata,
    input  logic        pready,
    output int          o_fail_count,
    output int          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [16:0] NORM_ONE     = 17'h10000;
    localparam logic [16:0] NORM_QUARTER = 17'h04000;
    localparam logic [16:0] NORM_HALF    = 17'h08000;
    localparam logic [16:0] NORM_3Q      = 17'h0C000;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       last;
    } t_pixel;

    logic [CFG_W-1:0] fallback_max;
    logic [CFG_W-1:0] min_span_cfg;
    logic [15:0]      lowest_depth;
    logic [15:0]      highest_depth;
    logic             range_valid;
    logic [15:0]      range_base;
    logic [15:0]      range_span;
    t_pixel           expected_pixels[$];
    int               fail_count = 0;

    assign o_fail_count = fail_count;

    task report_mismatch(string what, logic [31:0] want, logic [31:0] got);
        $display("MISMATCH %s: expected 0x%0h, got 0x%0h at %0t", what, want, got, $time);
        fail_count++;
    endtask

    function void clear_range();
        lowest_depth  = 16'hFFFF;
        highest_depth = 16'h0000;
        range_valid   = 1'b0;
        range_base    = 16'h0000;
        range_span    = 16'h0000;
    endfunction

    function void latch_depth_range();
        logic [15:0] lo;
        logic [15:0] hi;
        logic [15:0] span;
        lo = 16'h0000;
        hi = fallback_max;
        if (range_valid && lowest_depth < highest_depth) begin
            lo = lowest_depth;
            hi = highest_depth;
        end
        span = hi - lo;
        if (span < min_span_cfg) begin
            span = min_span_cfg;
        end
        if (span == 16'h0000) begin
            span = 16'h0001;
        end
        range_base = lo;
        range_span = span;
    endfunction

    function automatic logic [7:0] ramp255(logic [16:0] u);
        logic [31:0] prod;
        prod = 32'd255 * 32'(u);
        return prod[21:14];
    endfunction

    function automatic t_pixel jet_color(logic [16:0] t, logic last);
        t_pixel px;
        t_seg   seg;
        px = '0;
        px.last = last;
        if (t < NORM_QUARTER) begin
            seg = SEG_BLUE_CYAN;
        end else if (t < NORM_HALF) begin
            seg = SEG_CYAN_GREEN;
        end else if (t < NORM_3Q) begin
            seg = SEG_GREEN_YELLOW;
        end else begin
            seg = SEG_YELLOW_RED;
        end
        case (seg)
            SEG_BLUE_CYAN: begin
                px.green = ramp255(t);
                px.blue  = CHAN_FULL;
            end
            SEG_CYAN_GREEN: begin
                px.green = CHAN_FULL;
                px.blue  = ramp255(NORM_HALF - t);
            end
            SEG_GREEN_YELLOW: begin
                px.red   = ramp255(t - NORM_HALF);
                px.green = CHAN_FULL;
            end
            default: begin
                px.red   = CHAN_FULL;
                px.green = ramp255(NORM_ONE - t);
            end
        endcase
        return px;
    endfunction

    function t_pixel render_pixel(logic [15:0] depth, logic valid, logic last);
        t_pixel      px;
        logic [31:0] scaled;
        logic [31:0] n;
        px = '0;
        px.last = last;
        if (valid) begin
            n = 32'd0;
            if (depth > range_base) begin
                scaled = {depth - range_base, 16'h0000};
                n = scaled / 32'(range_span);
                if (n > 32'(NORM_ONE)) begin
                    n = 32'(NORM_ONE);
                end
            end
            px = jet_color(17'(32'(NORM_ONE) - n), last);
        end
        return px;
    endfunction

    always @(posedge i_clk) begin
        t_pixel      got;
        t_pixel      want;
        logic        depth_ok;
        logic [15:0] reg_value;
        if (!i_rst_n) begin
            fallback_max = FALLBACK_RESET;
            min_span_cfg = MIN_SPAN_RESET;
            clear_range();
            expected_pixels.delete();
        end else begin
            if (psel && penable && pready) begin
                reg_value = (paddr[2] == REG_FALLBACK) ? fallback_max : min_span_cfg;
                if (pwrite) begin
                    case (paddr[2])
                        REG_FALLBACK: fallback_max = pwdata[15:0];
                        REG_MIN_SPAN: min_span_cfg = pwdata[15:0];
                    endcase
                end else if (prdata !== {16'h0000, reg_value}) begin
                    report_mismatch("register read", {16'h0000, reg_value}, prdata);
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                depth_ok = (i_s_tdata != 16'h0000) && !i_s_tuser[1];
                if (t_pixel_cmd'(i_s_tuser[0]) == CMD_MEASURE) begin
                    if (depth_ok) begin
                        if (i_s_tdata < lowest_depth) begin
                            lowest_depth = i_s_tdata;
                        end
                        if (i_s_tdata > highest_depth) begin
                            highest_depth = i_s_tdata;
                        end
                        range_valid = 1'b1;
                    end
                end else begin
                    if (range_span == 16'h0000) begin
                        latch_depth_range();
                    end
                    expected_pixels.push_back(render_pixel(i_s_tdata, depth_ok, i_s_tlast));
                    if (i_s_tlast) begin
                        clear_range();
                    end
                end
            end
            if (i_m_tvalid && i_m_tready) begin
                got.red   = i_m_tdata[7:0];
                got.green = i_m_tdata[15:8];
                got.blue  = i_m_tdata[23:16];
                got.last  = i_m_tlast;
                if (expected_pixels.size() == 0) begin
                    report_mismatch("result with no pending pixel", 32'd0, {7'd0, got});
                end else begin
                    want = expected_pixels.pop_front();
                    if (got.red !== want.red) begin
                        report_mismatch("red", 32'(want.red), 32'(got.red));
                    end
                    if (got.green !== want.green) begin
                        report_mismatch("green", 32'(want.green), 32'(got.green));
                    end
                    if (got.blue !== want.blue) begin
                        report_mismatch("blue", 32'(want.blue), 32'(got.blue));
                    end
                    if (got.last !== want.last) begin
                        report_mismatch("last pixel", 32'(want.last), 32'(got.last));
                    end
                end
            end
        end
        o_pending <= expected_pixels.size();
    end

endmodule

[dv/tb.sv]
// ----------------------------------------------------------------------------
// Depth colormap core testbench
// Streams measure and render passes of depth frames into the core under
// several range settings, with random gaps and stalls on both streams and
// one long output stall, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import dajc_pkg::*;
    import dajc_tb_pkg::*;

    logic        i_clk    = 1'b0;
    logic        i_rst_n  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata  = '0;
    logic [1:0]  s_tuser  = '0;
    logic        s_tlast  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;
    logic        m_tlast;
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [2:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;
    int          fail_count;
    int          pending;
    int          items_sent      = 0;
    bit          sender_gaps     = 1'b1;
    bit          receiver_stalls = 1'b1;
    bit          long_hold_req   = 1'b0;

    always #5 i_clk = ~i_clk;

    depth_autorange_jet_colormap_core DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .i_s_axis_tlast  (s_tlast),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tlast  (m_tlast),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    jet_pixel_checker pixel_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_s_tuser    (s_tuser),
        .i_s_tlast    (s_tlast),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .i_m_tlast    (m_tlast),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    task automatic send_pixel(t_pixel_cmd cmd, int depth, bit not_finite, bit last);
        int gap;
        gap = sender_gaps ? $urandom_range(0, 4) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= depth[15:0];
        s_tuser  <= {not_finite, cmd};
        s_tlast  <= last;
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        items_sent++;
    endtask

    task automatic apb_access(bit write, logic idx, logic [15:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= write;
        paddr   <= {idx, 2'b00};
        pwdata  <= {16'h0000, value};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    function automatic int pick_depth(int lo, int width);
        int d;
        case ($urandom_range(0, 19))
            0:       d = 0;
            1:       d = $urandom_range(0, 65535);
            2:       d = lo;
            3:       d = lo + width;
            default: d = lo + $urandom_range(0, width);
        endcase
        return (d > 65535) ? 65535 : d;
    endfunction

    task automatic random_frame();
        int kind;
        int lo;
        int width;
        int mlen;
        int rlen;
        kind  = $urandom_range(0, 9);
        lo    = $urandom_range(1, 65535);
        width = $urandom_range(0, (1 << $urandom_range(0, 16)) - 1);
        mlen  = $urandom_range(1, 10);
        rlen  = $urandom_range(1, 10);
        if (kind == 0) begin
            repeat (4) begin
                send_pixel(t_pixel_cmd'($urandom_range(0, 1)), $urandom_range(0, 65535),
                           1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            end
        end else begin
            if (kind != 1) begin
                for (int i = 0; i < mlen; i++) begin
                    send_pixel(CMD_MEASURE, pick_depth(lo, width),
                               $urandom_range(0, 11) == 0, i == mlen - 1);
                end
            end
            if (kind != 2) begin
                lo    = (lo > width / 8) ? lo - width / 8 : 0;
                width = width + width / 4;
                for (int i = 0; i < rlen; i++) begin
                    if ($urandom_range(0, 15) == 0) begin
                        send_pixel(CMD_MEASURE, pick_depth(lo, width), 1'b0, 1'b0);
                    end
                    send_pixel(CMD_RENDER, pick_depth(lo, width),
                               $urandom_range(0, 11) == 0, i == rlen - 1);
                end
            end
        end
    endtask

    initial begin
        #8_000_000;
        $display("Some tests failed");
        $finish;
    end

    initial begin
        int gap;
        forever begin
            if (long_hold_req) begin
                m_tready <= 1'b0;
                repeat (300) @(posedge i_clk);
                long_hold_req = 1'b0;
            end
            gap = receiver_stalls ? $urandom_range(0, 4) : 0;
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            m_tready <= 1'b1;
            @(posedge i_clk);
            while (!m_tvalid) @(posedge i_clk);
        end
    end

    initial begin
        int target;
        int fallback;
        int span;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Full-scale range with invalid measure pixels and an early measure frame end.
        send_pixel(CMD_MEASURE, 65535, 1'b0, 1'b0);
        send_pixel(CMD_MEASURE, 1, 1'b0, 1'b0);
        send_pixel(CMD_MEASURE, 0, 1'b0, 1'b0);
        send_pixel(CMD_MEASURE, 100, 1'b1, 1'b1);
        send_pixel(CMD_MEASURE, 40000, 1'b0, 1'b0);
        send_pixel(CMD_RENDER, 0, 1'b0, 1'b0);
        send_pixel(CMD_RENDER, 1, 1'b0, 1'b0);
        send_pixel(CMD_RENDER, 65535, 1'b0, 1'b0);
        send_pixel(CMD_RENDER, 500, 1'b1, 1'b0);
        send_pixel(CMD_RENDER, 32768, 1'b0, 1'b1);
        // Render with nothing measured falls back to the default range.
        send_pixel(CMD_RENDER, 2500, 1'b0, 1'b0);
        send_pixel(CMD_RENDER, 6000, 1'b0, 1'b1);
        // Only invalid depths measured.
        send_pixel(CMD_MEASURE, 0, 1'b0, 1'b0);
        send_pixel(CMD_MEASURE, 7, 1'b1, 1'b1);
        send_pixel(CMD_RENDER, 1250, 1'b0, 1'b1);
        // A single measured depth gives no usable range.
        send_pixel(CMD_MEASURE, 300, 1'b0, 1'b1);
        send_pixel(CMD_RENDER, 300, 1'b0, 1'b1);
        // A narrow range is widened to the minimum span.
        send_pixel(CMD_MEASURE, 100, 1'b0, 1'b0);
        send_pixel(CMD_MEASURE, 103, 1'b0, 1'b1);
        send_pixel(CMD_RENDER, 99, 1'b0, 1'b0);
        send_pixel(CMD_RENDER, 105, 1'b0, 1'b1);
        // A measure pixel in the middle of a render pass leaves the latched range alone and is cleared with the pass.
        send_pixel(CMD_MEASURE, 1000, 1'b0, 1'b0);
        send_pixel(CMD_MEASURE, 2000, 1'b0, 1'b1);
        send_pixel(CMD_RENDER, 1500, 1'b0, 1'b0);
        send_pixel(CMD_MEASURE, 10, 1'b0, 1'b0);
        send_pixel(CMD_RENDER, 1900, 1'b0, 1'b1);
        send_pixel(CMD_RENDER, 15, 1'b0, 1'b1);
        wait_idle();

        for (int phase = 0; phase < 9; phase++) begin
            sender_gaps     = (phase % 3) != 2;
            receiver_stalls = (phase % 4) != 3;
            case (phase)
                0: begin
                    fallback = int'(FALLBACK_RESET);
                    span     = int'(MIN_SPAN_RESET);
                end
                1: begin
                    fallback = 1;
                    span     = 1;
                end
                2: begin
                    fallback = 65535;
                    span     = 65535;
                end
                3: begin
                    fallback = 65535;
                    span     = 1;
                end
                4: begin
                    fallback = 1;
                    span     = 65535;
                end
                default: begin
                    fallback = $urandom_range(1, 65535);
                    span     = $urandom_range(1, (1 << $urandom_range(1, 16)) - 1);
                end
            endcase
            if (phase > 0) begin
                apb_access(1'b1, REG_FALLBACK, fallback[15:0]);
                apb_access(1'b1, REG_MIN_SPAN, span[15:0]);
            end
            apb_access(1'b0, REG_FALLBACK, 16'h0000);
            apb_access(1'b0, REG_MIN_SPAN, 16'h0000);
            if (phase == 5) begin
                sender_gaps   = 1'b0;
                long_hold_req = 1'b1;
                for (int i = 0; i < 24; i++) begin
                    send_pixel(CMD_RENDER, $urandom_range(1, 65535), 1'b0, i == 23);
                end
                sender_gaps = 1'b1;
            end
            target = items_sent + 110;
            while (items_sent < target) random_frame();
            wait_idle();
        end

        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

[files.f]
hw/rtl/dajc_pkg.sv
hw/rtl/dajc_regs.sv
hw/rtl/dajc_ctrl.sv
hw/rtl/dajc_datapath.sv
hw/rtl/depth_autorange_jet_colormap_core.sv
dv/dajc_tb_pkg.sv
dv/jet_pixel_checker.sv
dv/tb.sv
